>>> rtl/ibhq_pkg.sv
`timescale 1ns / 1ps
package ibhq_pkg;

  localparam int NUM_ELEMENTS_DEF = 4096;
  localparam int KEY_W = 32;
  localparam int ELEM_W = 12;
  localparam int COUNT_W = 13;
  localparam int MODE_W = 2;
  localparam int STATUS_W = 2;
  localparam int MARK_W = 2;

  localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RESET = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_REMOVED = 2'd3;

  localparam logic [MARK_W-1:0] MARK_UNQUEUED = 2'd0;
  localparam logic [MARK_W-1:0] MARK_QUEUED = 2'd1;
  localparam logic [MARK_W-1:0] MARK_REMOVED = 2'd2;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ELEM_W-1:0] element;
    logic [KEY_W-1:0] key;
    logic [COUNT_W-1:0] count;
  } result_t;

endpackage

>>> rtl/ibhq_in_if.sv
`timescale 1ns / 1ps
interface ibhq_in_if;
  logic valid;
  logic ready;
  logic [ibhq_pkg::MODE_W-1:0] mode;
  logic [ibhq_pkg::ELEM_W-1:0] element;
  logic [ibhq_pkg::KEY_W-1:0] key;

  modport source (output valid, mode, element, key, input ready);
  modport sink (input valid, mode, element, key, output ready);
endinterface

>>> rtl/ibhq_out_if.sv
`timescale 1ns / 1ps
interface ibhq_out_if;
  logic valid;
  logic ready;
  logic [ibhq_pkg::STATUS_W-1:0] status;
  logic [ibhq_pkg::ELEM_W-1:0] out_element;
  logic [ibhq_pkg::KEY_W-1:0] out_key;
  logic [ibhq_pkg::COUNT_W-1:0] count;

  modport source (output valid, status, out_element, out_key, count, input ready);
  modport sink (input valid, status, out_element, out_key, count, output ready);
endinterface

>>> rtl/ibhq_cmp.sv
`timescale 1ns / 1ps
module ibhq_cmp (
  input  logic [ibhq_pkg::KEY_W-1:0] a,
  input  logic [ibhq_pkg::KEY_W-1:0] b,
  input  logic                       order_is_max,
  output logic                       a_first
);
  assign a_first = order_is_max ? (a > b) : (a < b);
endmodule

>>> rtl/ibhq_core.sv
`timescale 1ns / 1ps
module ibhq_core #(
  parameter int NUM_ELEMENTS = ibhq_pkg::NUM_ELEMENTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ibhq_pkg::MODE_W-1:0]   in_mode,
  input  logic [ibhq_pkg::ELEM_W-1:0]   in_element,
  input  logic [ibhq_pkg::KEY_W-1:0]    in_key,
  input  logic                          order_is_max,
  output logic                          res_valid,
  input  logic                          res_ready,
  output ibhq_pkg::result_t             res
);
  localparam int AW = $clog2(NUM_ELEMENTS);
  localparam int CW = $clog2(NUM_ELEMENTS + 1);
  localparam int KW = ibhq_pkg::KEY_W;

  localparam logic [4:0] S_CLR = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_U_MARK = 5'd2;
  localparam logic [4:0] S_U_POS = 5'd3;
  localparam logic [4:0] S_UP_TOP = 5'd4;
  localparam logic [4:0] S_UP_HEAP = 5'd5;
  localparam logic [4:0] S_UP_CMP = 5'd6;
  localparam logic [4:0] S_R_TOP = 5'd7;
  localparam logic [4:0] S_R_LAST = 5'd8;
  localparam logic [4:0] S_R_LKEY = 5'd9;
  localparam logic [4:0] S_DN_L = 5'd10;
  localparam logic [4:0] S_DN_R = 5'd11;
  localparam logic [4:0] S_DN_LK = 5'd12;
  localparam logic [4:0] S_DN_RK = 5'd13;
  localparam logic [4:0] S_DN_MOVE = 5'd14;
  localparam logic [4:0] S_FIN = 5'd15;

  logic [AW-1:0] heap_mem [NUM_ELEMENTS];
  logic [AW-1:0] pos_mem [NUM_ELEMENTS];
  logic [ibhq_pkg::MARK_W-1:0] mark_mem [NUM_ELEMENTS];
  logic [KW-1:0] key_mem [NUM_ELEMENTS];

  logic [AW-1:0] heap_q, pos_q;
  logic [ibhq_pkg::MARK_W-1:0] mark_q;
  logic [KW-1:0] key_q;

  logic heap_we, pos_we, mark_we, key_we;
  logic [AW-1:0] heap_waddr, heap_wdata, pos_waddr, pos_wdata, mark_waddr, key_waddr;
  logic [AW-1:0] heap_raddr, pos_raddr, mark_raddr, key_raddr;
  logic [ibhq_pkg::MARK_W-1:0] mark_wdata;
  logic [KW-1:0] key_wdata;

  logic [4:0] state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] s_r, s_nxt, e_r, e_nxt, p_r, p_nxt, le_r, le_nxt, re_r, re_nxt;
  logic [AW-1:0] best_r, best_nxt, be_r, be_nxt, clr_r, clr_nxt, taken_r, taken_nxt;
  logic [KW-1:0] k_r, k_nxt, bk_r, bk_nxt, taken_key_r, taken_key_nxt;
  logic [ibhq_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic clr_reply_r, clr_reply_nxt;
  logic r_ok_r, r_ok_nxt;

  logic [KW-1:0] cmp_a, cmp_b;
  logic cmp_first;
  logic [AW+1:0] lw, rw, nw;

  ibhq_cmp u_cmp (
    .a(cmp_a),
    .b(cmp_b),
    .order_is_max(order_is_max),
    .a_first(cmp_first)
  );

  always_ff @(posedge clk) begin
    if (heap_we) heap_mem[heap_waddr] <= heap_wdata;
    if (pos_we) pos_mem[pos_waddr] <= pos_wdata;
    if (mark_we) mark_mem[mark_waddr] <= mark_wdata;
    if (key_we) key_mem[key_waddr] <= key_wdata;
    heap_q <= heap_mem[heap_raddr];
    pos_q <= pos_mem[pos_raddr];
    mark_q <= mark_mem[mark_raddr];
    key_q <= key_mem[key_raddr];
  end

  assign lw = (AW+2)'({s_r, 1'b1});
  assign rw = lw + (AW+2)'(1);
  assign nw = (AW+2)'(cnt_r);

  assign in_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_FIN);
  assign res.status = status_r;
  assign res.element = ibhq_pkg::ELEM_W'(taken_r);
  assign res.key = taken_key_r;
  assign res.count = ibhq_pkg::COUNT_W'(cnt_r);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    s_nxt = s_r;
    e_nxt = e_r;
    p_nxt = p_r;
    le_nxt = le_r;
    re_nxt = re_r;
    best_nxt = best_r;
    be_nxt = be_r;
    clr_nxt = clr_r;
    taken_nxt = taken_r;
    k_nxt = k_r;
    bk_nxt = bk_r;
    taken_key_nxt = taken_key_r;
    status_nxt = status_r;
    clr_reply_nxt = clr_reply_r;
    r_ok_nxt = r_ok_r;
    heap_we = 1'b0;
    pos_we = 1'b0;
    mark_we = 1'b0;
    key_we = 1'b0;
    heap_waddr = s_r;
    heap_wdata = e_r;
    pos_waddr = e_r;
    pos_wdata = s_r;
    mark_waddr = clr_r;
    mark_wdata = ibhq_pkg::MARK_UNQUEUED;
    key_waddr = e_r;
    key_wdata = k_r;
    heap_raddr = s_r;
    pos_raddr = e_r;
    mark_raddr = AW'(in_element);
    key_raddr = heap_q;
    cmp_a = key_q;
    cmp_b = k_r;
    case (state_r)
      S_CLR: begin
        mark_we = 1'b1;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(NUM_ELEMENTS - 1)) begin
          clr_nxt = '0;
          cnt_nxt = '0;
          state_nxt = clr_reply_r ? S_FIN : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          status_nxt = ibhq_pkg::ST_OK;
          taken_nxt = '0;
          taken_key_nxt = '0;
          e_nxt = AW'(in_element);
          k_nxt = in_key;
          heap_raddr = '0;
          clr_reply_nxt = 1'b1;
          case (in_mode)
            ibhq_pkg::MODE_UPDATE: begin
              if (32'(in_element) < 32'(NUM_ELEMENTS)) begin
                state_nxt = S_U_MARK;
              end else begin
                status_nxt = ibhq_pkg::ST_FULL;
                state_nxt = S_FIN;
              end
            end
            ibhq_pkg::MODE_REMOVE: begin
              if (cnt_r == '0) begin
                status_nxt = ibhq_pkg::ST_EMPTY;
                state_nxt = S_CLR;
              end else begin
                state_nxt = S_R_TOP;
              end
            end
            ibhq_pkg::MODE_RESET: state_nxt = S_CLR;
            default: state_nxt = S_FIN;
          endcase
        end
      end
      S_U_MARK: begin
        if (mark_q == ibhq_pkg::MARK_REMOVED) begin
          status_nxt = ibhq_pkg::ST_REMOVED;
          state_nxt = S_FIN;
        end else begin
          key_we = 1'b1;
          if (mark_q == ibhq_pkg::MARK_QUEUED) begin
            state_nxt = S_U_POS;
          end else if (cnt_r == CW'(NUM_ELEMENTS)) begin
            status_nxt = ibhq_pkg::ST_FULL;
            state_nxt = S_FIN;
          end else begin
            mark_we = 1'b1;
            mark_waddr = e_r;
            mark_wdata = ibhq_pkg::MARK_QUEUED;
            s_nxt = AW'(cnt_r);
            cnt_nxt = cnt_r + CW'(1);
            state_nxt = S_UP_TOP;
          end
        end
      end
      S_U_POS: begin
        s_nxt = pos_q;
        state_nxt = S_UP_TOP;
      end
      S_UP_TOP: begin
        if (s_r == '0) begin
          heap_we = 1'b1;
          pos_we = 1'b1;
          state_nxt = S_FIN;
        end else begin
          p_nxt = (s_r - AW'(1)) >> 1;
          heap_raddr = (s_r - AW'(1)) >> 1;
          state_nxt = S_UP_HEAP;
        end
      end
      S_UP_HEAP: begin
        le_nxt = heap_q;
        state_nxt = S_UP_CMP;
      end
      S_UP_CMP: begin
        cmp_a = k_r;
        cmp_b = key_q;
        heap_we = 1'b1;
        pos_we = 1'b1;
        if (cmp_first) begin
          heap_wdata = le_r;
          pos_waddr = le_r;
          s_nxt = p_r;
          state_nxt = S_UP_TOP;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_R_TOP: begin
        taken_nxt = heap_q;
        heap_raddr = AW'(cnt_r - CW'(1));
        state_nxt = S_R_LAST;
      end
      S_R_LAST: begin
        taken_key_nxt = key_q;
        mark_we = 1'b1;
        mark_waddr = taken_r;
        mark_wdata = ibhq_pkg::MARK_REMOVED;
        e_nxt = heap_q;
        cnt_nxt = cnt_r - CW'(1);
        state_nxt = (cnt_r == CW'(1)) ? S_FIN : S_R_LKEY;
      end
      S_R_LKEY: begin
        k_nxt = key_q;
        s_nxt = '0;
        state_nxt = S_DN_L;
      end
      S_DN_L: begin
        heap_raddr = AW'(lw);
        r_ok_nxt = (rw < nw);
        state_nxt = (lw < nw) ? S_DN_R : S_DN_MOVE;
        best_nxt = s_r;
      end
      S_DN_R: begin
        le_nxt = heap_q;
        heap_raddr = AW'(rw);
        state_nxt = S_DN_LK;
      end
      S_DN_LK: begin
        re_nxt = heap_q;
        if (cmp_first) begin
          best_nxt = AW'(lw);
          bk_nxt = key_q;
          be_nxt = le_r;
        end else begin
          best_nxt = s_r;
          bk_nxt = k_r;
          be_nxt = e_r;
        end
        state_nxt = r_ok_r ? S_DN_RK : S_DN_MOVE;
      end
      S_DN_RK: begin
        cmp_b = bk_r;
        if (cmp_first) begin
          best_nxt = AW'(rw);
          be_nxt = re_r;
        end
        state_nxt = S_DN_MOVE;
      end
      S_DN_MOVE: begin
        heap_we = 1'b1;
        pos_we = 1'b1;
        if (best_r == s_r) begin
          state_nxt = S_FIN;
        end else begin
          heap_wdata = be_r;
          pos_waddr = be_r;
          s_nxt = best_r;
          state_nxt = S_DN_L;
        end
      end
      S_FIN: begin
        if (res_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      cnt_r <= '0;
      clr_r <= '0;
      clr_reply_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      clr_r <= clr_nxt;
      clr_reply_r <= clr_reply_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r <= s_nxt;
    e_r <= e_nxt;
    p_r <= p_nxt;
    le_r <= le_nxt;
    re_r <= re_nxt;
    best_r <= best_nxt;
    be_r <= be_nxt;
    taken_r <= taken_nxt;
    k_r <= k_nxt;
    bk_r <= bk_nxt;
    taken_key_r <= taken_key_nxt;
    status_r <= status_nxt;
    r_ok_r <= r_ok_nxt;
  end
endmodule

>>> rtl/indexed_binary_heap_queue.sv
`timescale 1ns / 1ps
// Indexed binary heap priority queue over element numbers.
// The in_ch channel carries commands: update (write a key and insert or sift up
// the element), remove (take the top element) and reset all. Every command yields
// exactly one transfer on out_ch with a status, the removed element and key, and
// the number of queued elements afterwards. cfg_we with cfg_wdata writes the
// ordering bit (0 smallest key first, 1 largest first); the user must write it
// only while the block is idle, which the block itself does not enforce.
// One command is worked at a time by a sequencer around memories with one write
// and one read port each and one shared key comparator. An update sifts the
// element up a heap level at a time, and a remove sifts the last element down from
// the root. A remove on an empty heap and a reset all run a mark clearing pass,
// one entry per cycle, before they answer.
// in_ch.ready rises again as the result moves to the output register.
// After rst_n the same clearing pass runs before in_ch.ready rises.
// Results sit in an output register; while out_ch is stalled the next command
// is still taken, and the one after that waits until the register frees.
module indexed_binary_heap_queue #(
  parameter int NUM_ELEMENTS = ibhq_pkg::NUM_ELEMENTS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  ibhq_in_if.sink      in_ch,
  ibhq_out_if.source   out_ch,
  input  logic         cfg_we,
  input  logic         cfg_wdata
);
  logic order_is_max_r;
  logic res_valid, res_ready;
  ibhq_pkg::result_t res;
  logic out_valid_r;
  ibhq_pkg::result_t out_r;

  ibhq_core #(.NUM_ELEMENTS(NUM_ELEMENTS)) u_core (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .in_mode(in_ch.mode),
    .in_element(in_ch.element),
    .in_key(in_ch.key),
    .order_is_max(order_is_max_r),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res)
  );

  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_is_max_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) order_is_max_r <= cfg_wdata;
      if (res_ready) out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) out_r <= res;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.status = out_r.status;
  assign out_ch.out_element = out_r.element;
  assign out_ch.out_key = out_r.key;
  assign out_ch.count = out_r.count;
endmodule
